// ----- design/bppr_pkg.sv -----
// Package: constants, types and helpers for the bad-pixel proximity reject block.
`default_nettype none
package bppr_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int FRAC_BITS   = 4;
  localparam int COORD_W     = 16;
  localparam int RADIUS_W    = 8;
  localparam int COUNT_W     = 9;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);
  localparam logic [COUNT_W-1:0]  DEPTH_CNT    = COUNT_W'(TABLE_DEPTH);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } entry_t;

  // whole-pixel part of |a - b|
  function automatic logic [COORD_W-1:0] whole_dist(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d >> FRAC_BITS;
  endfunction

endpackage
`default_nettype wire

// ----- design/bad_pixel_proximity_reject.sv -----
// Top level: bad-pixel table with per-query proximity scan over a synchronous memory.
//
// channel   | handshake         | payload
// ----------+-------------------+-------------------------------------------
// request   | start / busy      | req_type, coord_x, coord_y
// result    | done (1 cycle)    | is_query, keep, table_full, entry_count
// config    | cfg_we            | cfg_wdata (reject_radius)
//
// Load, clear and unused codes: the result beat follows on the next cycle.
// Query: scans the n stored entries in order, up to TABLE_DEPTH (256) of them;
// the table memory is read one entry per cycle and the scan stops at the first hit.
// A new request is taken while the previous result beat is shown.
// rst is synchronous: table empty, radius 1. Table contents are not cleared.
// The receiver cannot stall; each result beat lasts exactly one cycle.
`default_nettype none
module bad_pixel_proximity_reject (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    req_type,
  input  wire logic [bppr_pkg::COORD_W-1:0]  coord_x,
  input  wire logic [bppr_pkg::COORD_W-1:0]  coord_y,
  input  wire logic                          cfg_we,
  input  wire logic [bppr_pkg::RADIUS_W-1:0] cfg_wdata,
  output logic                               done,
  output logic                               is_query,
  output logic                               keep,
  output logic                               table_full,
  output logic [bppr_pkg::COUNT_W-1:0]       entry_count
);

  bppr_pkg::state_t state, state_next;
  logic [bppr_pkg::RADIUS_W-1:0] radius;
  logic [bppr_pkg::COUNT_W-1:0]  stored_count, stored_count_next;
  logic [bppr_pkg::ADDR_W-1:0]   scan_idx, scan_idx_next;
  logic [bppr_pkg::COORD_W-1:0]  qx, qy;

  bppr_pkg::entry_t mem [bppr_pkg::TABLE_DEPTH];
  bppr_pkg::entry_t rd_data;
  logic [bppr_pkg::ADDR_W-1:0] rd_addr;
  logic wr_en;

  logic done_next, is_query_next, keep_next, full_next;
  logic hit, last;

  assign busy = (state != bppr_pkg::ST_IDLE);

  assign hit  = (bppr_pkg::whole_dist(rd_data.x, qx) <= bppr_pkg::COORD_W'(radius)) &&
                (bppr_pkg::whole_dist(rd_data.y, qy) <= bppr_pkg::COORD_W'(radius));
  assign last = ((bppr_pkg::COUNT_W'(scan_idx) + bppr_pkg::COUNT_W'(1)) == stored_count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[stored_count[bppr_pkg::ADDR_W-1:0]] <= '{x: coord_x, y: coord_y};
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next        = state;
    scan_idx_next     = scan_idx;
    stored_count_next = stored_count;
    rd_addr           = '0;
    wr_en             = 1'b0;
    done_next         = 1'b0;
    is_query_next     = 1'b0;
    keep_next         = 1'b0;
    full_next         = 1'b0;
    unique case (state)
      bppr_pkg::ST_IDLE: begin
        if (start) begin
          unique case (req_type)
            bppr_pkg::REQ_LOAD: begin
              done_next = 1'b1;
              if (stored_count < bppr_pkg::DEPTH_CNT) begin
                wr_en             = 1'b1;
                stored_count_next = stored_count + bppr_pkg::COUNT_W'(1);
              end else begin
                full_next = 1'b1;
              end
            end
            bppr_pkg::REQ_QUERY: begin
              if (stored_count == '0) begin
                done_next     = 1'b1;
                is_query_next = 1'b1;
                keep_next     = 1'b1;
              end else begin
                state_next    = bppr_pkg::ST_SCAN;
                scan_idx_next = '0;
              end
            end
            bppr_pkg::REQ_CLEAR: begin
              done_next         = 1'b1;
              stored_count_next = '0;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      bppr_pkg::ST_SCAN: begin
        rd_addr = scan_idx + bppr_pkg::ADDR_W'(1);
        if (hit || last) begin
          done_next     = 1'b1;
          is_query_next = 1'b1;
          keep_next     = !hit;
          state_next    = bppr_pkg::ST_IDLE;
        end else begin
          scan_idx_next = scan_idx + bppr_pkg::ADDR_W'(1);
        end
      end
      default: begin
        state_next = bppr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bppr_pkg::ST_IDLE;
      stored_count <= '0;
      radius       <= bppr_pkg::RADIUS_RESET;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      stored_count <= stored_count_next;
      done         <= done_next;
      if (cfg_we) begin
        radius <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    if (start && !busy) begin
      qx <= coord_x;
      qy <= coord_y;
    end
    if (done_next) begin
      is_query    <= is_query_next;
      keep        <= keep_next;
      table_full  <= full_next;
      entry_count <= stored_count_next;
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == bppr_pkg::ST_SCAN) |-> (bppr_pkg::COUNT_W'(scan_idx) < stored_count))
    else $error("scan index beyond stored entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= bppr_pkg::DEPTH_CNT)
    else $error("stored count exceeds table depth");

  a_keep_only_query: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_query || !keep) && !(is_query && table_full))
    else $error("result flags inconsistent");

  a_empty_query_kept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == bppr_pkg::REQ_QUERY && stored_count == '0)
      |=> (done && keep && is_query))
    else $error("query on empty table not kept");

  a_scan_ends_with_beat: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == bppr_pkg::ST_SCAN && state == bppr_pkg::ST_IDLE) |-> (done && is_query))
    else $error("scan ended without a result beat");

endmodule
`default_nettype wire

// ----- tb/bad_pixel_proximity_reject_tb.sv -----
// Testbench for the bad-pixel proximity reject block: directed table, then random phases.
`timescale 1ns / 1ps
module bad_pixel_proximity_reject_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic                         is_query;
    logic                         keep;
    logic                         table_full;
    logic [bppr_pkg::COUNT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic [1:0]                   req;
    logic [bppr_pkg::COORD_W-1:0] x;
    logic [bppr_pkg::COORD_W-1:0] y;
    logic                         typed;
    result_t                      res;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [1:0]                    req_type = bppr_pkg::REQ_LOAD;
  logic [bppr_pkg::COORD_W-1:0]  coord_x = '0;
  logic [bppr_pkg::COORD_W-1:0]  coord_y = '0;
  logic                          cfg_we = 1'b0;
  logic [bppr_pkg::RADIUS_W-1:0] cfg_wdata = '0;
  logic                          busy;
  logic                          done;
  logic                          is_query;
  logic                          keep;
  logic                          table_full;
  logic [bppr_pkg::COUNT_W-1:0]  entry_count;

  bad_pixel_proximity_reject dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .is_query   (is_query),
    .keep       (keep),
    .table_full (table_full),
    .entry_count(entry_count)
  );

  always #5 clk = ~clk;

  // shadow of the block's table and register
  logic [bppr_pkg::COORD_W-1:0]  bad_x [0:bppr_pkg::TABLE_DEPTH-1];
  logic [bppr_pkg::COORD_W-1:0]  bad_y [0:bppr_pkg::TABLE_DEPTH-1];
  int                            stored_entries = 0;
  logic [bppr_pkg::RADIUS_W-1:0] radius = bppr_pkg::RADIUS_RESET;

  result_t pending_results [$];
  int      idle_pct = 0;
  int      errors = 0;
  int      n_checked = 0;
  int      n_loads = 0;
  int      n_drops = 0;
  int      n_queries = 0;
  int      n_rejects = 0;
  int      n_clears = 0;
  int      n_unused = 0;
  int      n_radius = 0;
  row_t    dir_rows [0:20];

  function automatic result_t predict_request(input logic [1:0] req,
                                              input logic [bppr_pkg::COORD_W-1:0] x,
                                              input logic [bppr_pkg::COORD_W-1:0] y);
    result_t                      r;
    logic [bppr_pkg::COORD_W-1:0] dx;
    logic [bppr_pkg::COORD_W-1:0] dy;
    r = '0;
    unique case (req)
      bppr_pkg::REQ_LOAD: begin
        n_loads++;
        if (stored_entries < bppr_pkg::TABLE_DEPTH) begin
          bad_x[stored_entries] = x;
          bad_y[stored_entries] = y;
          stored_entries++;
        end else begin
          r.table_full = 1'b1;
          n_drops++;
        end
      end
      bppr_pkg::REQ_QUERY: begin
        n_queries++;
        r.is_query = 1'b1;
        r.keep = 1'b1;
        for (int k = 0; k < stored_entries && r.keep; k++) begin
          dx = (bad_x[k] >= x) ? bad_x[k] - x : x - bad_x[k];
          dy = (bad_y[k] >= y) ? bad_y[k] - y : y - bad_y[k];
          if ((dx >> bppr_pkg::FRAC_BITS) <= radius && (dy >> bppr_pkg::FRAC_BITS) <= radius)
            r.keep = 1'b0;
        end
        if (!r.keep) n_rejects++;
      end
      bppr_pkg::REQ_CLEAR: begin
        stored_entries = 0;
        n_clears++;
      end
      default: n_unused++;
    endcase
    r.entry_count = bppr_pkg::COUNT_W'(stored_entries);
    return r;
  endfunction

  function automatic row_t make_row(input logic [1:0] req,
                                    input logic [bppr_pkg::COORD_W-1:0] x,
                                    input logic [bppr_pkg::COORD_W-1:0] y, input int typed,
                                    input int q, input int k, input int f, input int c);
    row_t r;
    r.req = req;
    r.x = x;
    r.y = y;
    r.typed = 1'(typed);
    r.res.is_query = 1'(q);
    r.res.keep = 1'(k);
    r.res.table_full = 1'(f);
    r.res.entry_count = bppr_pkg::COUNT_W'(c);
    return r;
  endfunction

  // leaves start high on return; caller either sends again or lowers it
  task automatic send_item(input logic [1:0] req, input logic [bppr_pkg::COORD_W-1:0] x,
                           input logic [bppr_pkg::COORD_W-1:0] y, input logic typed,
                           input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req_type <= req;
    coord_x <= x;
    coord_y <= y;
    do @(posedge clk); while (busy);
    r = predict_request(req, x, y);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // mode 0 mixed, 1 load only, 2 query only
  task automatic random_item(input int mode);
    int                           sel;
    int                           k;
    int                           span;
    logic [1:0]                   req;
    logic [bppr_pkg::COORD_W-1:0] x;
    logic [bppr_pkg::COORD_W-1:0] y;
    sel = $urandom_range(99);
    x = bppr_pkg::COORD_W'($urandom);
    y = bppr_pkg::COORD_W'($urandom);
    if (mode == 1) req = bppr_pkg::REQ_LOAD;
    else if (mode == 2) req = bppr_pkg::REQ_QUERY;
    else if (sel < 40) req = bppr_pkg::REQ_LOAD;
    else if (sel < 90) req = bppr_pkg::REQ_QUERY;
    else if (sel < 97) req = bppr_pkg::REQ_CLEAR;
    else req = REQ_UNUSED;
    if ((req == bppr_pkg::REQ_LOAD || req == bppr_pkg::REQ_QUERY) && stored_entries > 0 &&
        $urandom_range(99) < ((req == bppr_pkg::REQ_QUERY) ? 70 : 25)) begin
      k = $urandom_range(stored_entries - 1);
      span = (int'(radius) + 2) * 16;
      x = bad_x[k] + bppr_pkg::COORD_W'(int'($urandom_range(2 * span)) - span);
      y = bad_y[k] + bppr_pkg::COORD_W'(int'($urandom_range(2 * span)) - span);
    end
    send_item(req, x, y, 1'b0, '0);
  endtask

  task automatic set_radius(input logic [bppr_pkg::RADIUS_W-1:0] value);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius = value;
    n_radius++;
  endtask

  task automatic run_phase(input int pct, input logic [bppr_pkg::RADIUS_W-1:0] value,
                           input int n);
    set_radius(value);
    idle_pct = pct;
    repeat (n) random_item(0);
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && done) begin
      got = '{is_query, keep, table_full, entry_count};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat q=%0b keep=%0b full=%0b count=%0d",
                 $time, got.is_query, got.keep, got.table_full, got.entry_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got !== want) begin
          $display("%0t: mismatch: expected q=%0b keep=%0b full=%0b count=%0d,",
                   $time, want.is_query, want.keep, want.table_full, want.entry_count,
                   " got q=%0b keep=%0b full=%0b count=%0d",
                   got.is_query, got.keep, got.table_full, got.entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_rows[0]  = make_row(bppr_pkg::REQ_QUERY, 16'h0000, 16'h0000, 1, 1, 1, 0, 0);
    dir_rows[1]  = make_row(REQ_UNUSED,          16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 0);
    dir_rows[2]  = make_row(bppr_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
    dir_rows[3]  = make_row(bppr_pkg::REQ_LOAD,  16'h0100, 16'h0100, 1, 0, 0, 0, 1);
    dir_rows[4]  = make_row(bppr_pkg::REQ_QUERY, 16'h0100, 16'h0100, 1, 1, 0, 0, 1);
    dir_rows[5]  = make_row(bppr_pkg::REQ_QUERY, 16'h011F, 16'h0100, 0, 0, 0, 0, 0);
    dir_rows[6]  = make_row(bppr_pkg::REQ_QUERY, 16'h0120, 16'h0100, 0, 0, 0, 0, 0);
    dir_rows[7]  = make_row(bppr_pkg::REQ_QUERY, 16'h00E1, 16'h0100, 0, 0, 0, 0, 0);
    dir_rows[8]  = make_row(bppr_pkg::REQ_QUERY, 16'h00E0, 16'h0100, 0, 0, 0, 0, 0);
    dir_rows[9]  = make_row(bppr_pkg::REQ_QUERY, 16'h0100, 16'h00E0, 0, 0, 0, 0, 0);
    dir_rows[10] = make_row(bppr_pkg::REQ_LOAD,  16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 2);
    dir_rows[11] = make_row(bppr_pkg::REQ_LOAD,  16'h0000, 16'h0000, 1, 0, 0, 0, 3);
    dir_rows[12] = make_row(bppr_pkg::REQ_QUERY, 16'hFFF0, 16'h0000, 0, 0, 0, 0, 0);
    dir_rows[13] = make_row(bppr_pkg::REQ_QUERY, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0, 3);
    dir_rows[14] = make_row(bppr_pkg::REQ_QUERY, 16'h0010, 16'h001F, 0, 0, 0, 0, 0);
    dir_rows[15] = make_row(bppr_pkg::REQ_QUERY, 16'h8000, 16'h8000, 1, 1, 1, 0, 3);
    dir_rows[16] = make_row(REQ_UNUSED,          16'h1234, 16'h5678, 1, 0, 0, 0, 3);
    dir_rows[17] = make_row(bppr_pkg::REQ_CLEAR, 16'hFFFF, 16'h0000, 1, 0, 0, 0, 0);
    dir_rows[18] = make_row(bppr_pkg::REQ_QUERY, 16'h0100, 16'h0100, 1, 1, 1, 0, 0);
    dir_rows[19] = make_row(bppr_pkg::REQ_LOAD,  16'hAAAA, 16'h5555, 1, 0, 0, 0, 1);
    dir_rows[20] = make_row(bppr_pkg::REQ_QUERY, 16'h5555, 16'hAAAA, 0, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].req, dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed,
                dir_rows[i].res);
    start <= 1'b0;

    run_phase(10, 8'd0, 120);
    run_phase(53, 8'd255, 120);

    // fill to capacity, overflow, then queries on the full table
    set_radius(bppr_pkg::RADIUS_W'($urandom_range(2, 40)));
    idle_pct = 0;
    send_item(bppr_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 1'b0, '0);
    repeat (bppr_pkg::TABLE_DEPTH + 4) random_item(1);
    repeat (16) random_item(2);
    send_item(bppr_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 1'b0, '0);
    start <= 1'b0;

    run_phase(0, bppr_pkg::RADIUS_W'($urandom_range(0, 255)), 65);
    run_phase(0, 8'd1, 65);

    for (int i = 0; i < 5000 && pending_results.size() > 0; i++) @(posedge clk);
    repeat (300) @(posedge clk);
    if (pending_results.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors += pending_results.size();
    end

    $display("Checked %0d results: %0d loads (%0d dropped on full table),",
             n_checked, n_loads, n_drops, " %0d queries (%0d rejected),",
             n_queries, n_rejects);
    $display("%0d clears, %0d unused codes, %0d radius settings, %0d errors",
             n_clears, n_unused, n_radius, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
